FILE: rtl/bsp_pkg.sv
package bsp_pkg;

	localparam int IQ = 28;
	localparam int ANG_W = 16;
	localparam int OUT_W = 20;
	localparam int CFG_W = 16;
	localparam logic [31:0] HALF_PI_Q = 32'd421657428;
	localparam logic signed [31:0] SQRT3_HALF_Q = 32'sd232471924;
	localparam logic signed [31:0] IONE = 32'sd268435456;
	localparam logic [CFG_W-1:0] Z_SCALE_RESET = 16'd8192;

	// Q28 working value; every intermediate stays well inside +/-32.0
	typedef logic signed [33:0] q_t;

	typedef struct packed {
		logic [ANG_W-1:0] u_angle;
		logic [ANG_W-1:0] v_angle;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x_coord;
		logic signed [OUT_W-1:0] y_coord;
		logic signed [OUT_W-1:0] z_coord;
	} out_t;

	// rounded-half-up Q28 product of two 34-bit operands
	function automatic q_t qmul(input q_t a, input q_t b);
		logic signed [67:0] p;
		begin
			p = a * b + 68'sd134217728;
			qmul = 34'(p >>> IQ);
		end
	endfunction

	function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
			input int s);
		begin
			if (s == 0) rsh = v;
			else rsh = (v + (64'sd1 <<< (s - 1))) >>> s;
		end
	endfunction

endpackage

FILE: rtl/bsp_sin.sv
// Sine of a 16-bit turn angle in Q28; a chain of registered stages.
// Series stages alternate: one Q28 multiply, then one constant divide
// done as a reciprocal multiply (exact for operands below 2^30).
module bsp_sin (
	input  logic clk,
	input  logic en,
	input  logic [bsp_pkg::ANG_W-1:0] ang,
	output logic signed [31:0] res
);
	localparam int N = 12;
	// ceil(2^k / d) with k = 30 + ceil(log2 d)
	localparam logic [30:0] RCP_110 = 31'd1249445032;
	localparam int SH_110 = 37;
	localparam logic [30:0] RCP_72 = 31'd1908874354;
	localparam int SH_72 = 37;
	localparam logic [30:0] RCP_42 = 31'd1636178018;
	localparam int SH_42 = 36;
	localparam logic [30:0] RCP_20 = 31'd1717986919;
	localparam int SH_20 = 35;
	localparam logic [30:0] RCP_6 = 31'd1431655766;
	localparam int SH_6 = 33;

	logic signed [31:0] x_s [N-1];
	logic signed [31:0] x2_s [1:8];
	logic neg_s [N];
	logic signed [31:0] r_s2, m_s3, r_s4, m_s5, r_s6, m_s7, r_s8, m_s9, r_s10, r_s11;
	logic [14:0] t;
	logic [46:0] xp;
	logic signed [31:0] cl;

	// truncating divide of a non-negative value below 2^30
	function automatic logic [29:0] cdiv(input logic [29:0] n, input logic [30:0] m,
			input int k);
		logic [60:0] p;
		begin
			p = n * m;
			cdiv = 30'(p >> k);
		end
	endfunction

	always_comb begin
		t = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
		xp = {32'd0, t} * {15'd0, bsp_pkg::HALF_PI_Q} + 47'd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= 32'(signed'(xp[46:14]));
			neg_s[0] <= ang[15];
			for (int i = 1; i < N - 1; i++) begin
				x_s[i] <= x_s[i-1];
			end
			for (int i = 1; i < N; i++) begin
				neg_s[i] <= neg_s[i-1];
			end
			x2_s[1] <= 32'(bsp_pkg::qmul(34'(x_s[0]), 34'(x_s[0])));
			for (int i = 2; i <= 8; i++) begin
				x2_s[i] <= x2_s[i-1];
			end
			r_s2 <= bsp_pkg::IONE - $signed({2'b00, cdiv(30'(x2_s[1]), RCP_110, SH_110)});
			m_s3 <= 32'(bsp_pkg::qmul(34'(x2_s[2]), 34'(r_s2)));
			r_s4 <= bsp_pkg::IONE - $signed({2'b00, cdiv(30'(m_s3), RCP_72, SH_72)});
			m_s5 <= 32'(bsp_pkg::qmul(34'(x2_s[4]), 34'(r_s4)));
			r_s6 <= bsp_pkg::IONE - $signed({2'b00, cdiv(30'(m_s5), RCP_42, SH_42)});
			m_s7 <= 32'(bsp_pkg::qmul(34'(x2_s[6]), 34'(r_s6)));
			r_s8 <= bsp_pkg::IONE - $signed({2'b00, cdiv(30'(m_s7), RCP_20, SH_20)});
			m_s9 <= 32'(bsp_pkg::qmul(34'(x2_s[8]), 34'(r_s8)));
			r_s10 <= bsp_pkg::IONE - $signed({2'b00, cdiv(30'(m_s9), RCP_6, SH_6)});
			r_s11 <= 32'(bsp_pkg::qmul(34'(x_s[10]), 34'(r_s10)));
		end
	end

	always_comb begin
		cl = (r_s11 > bsp_pkg::IONE) ? bsp_pkg::IONE : r_s11;
		res = neg_s[N-1] ? -cl : cl;
	end
endmodule

FILE: rtl/bsp_poly.sv
// Polynomial stages: sphere point to surface coordinates.
module bsp_poly #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic en,
	input  logic signed [31:0] su, cu, sv, cv,
	input  logic [bsp_pkg::CFG_W-1:0] z_scale,
	output bsp_pkg::out_t res
);
	typedef bsp_pkg::q_t w_t;
	w_t x_s1, y_s1, z_s1;
	w_t x2_s2, y2_s2, z2_s2, xy_s2, zx_s2, yz_s2, s_s2, a_s2, b_s2, c_s2;
	w_t px_s3, py_s3, ss_s3, s_s3, ab_s3, c_s3;
	w_t px_s4, py_s4, s3_s4, p_s4, s_s4;
	w_t px_s5, py_s5, pz_s5;
	w_t px_s6, py_s6, pz_s6;
	logic signed [50:0] zprod;

	// z scale product: 34 x 17 bits
	always_comb begin
		zprod = pz_s5 * $signed({1'b0, z_scale});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= bsp_pkg::qmul(34'(cu), 34'(sv));
			y_s1 <= bsp_pkg::qmul(34'(su), 34'(sv));
			z_s1 <= 34'(cv);
			x2_s2 <= bsp_pkg::qmul(x_s1, x_s1);
			y2_s2 <= bsp_pkg::qmul(y_s1, y_s1);
			z2_s2 <= bsp_pkg::qmul(z_s1, z_s1);
			xy_s2 <= bsp_pkg::qmul(x_s1, y_s1);
			zx_s2 <= bsp_pkg::qmul(z_s1, x_s1);
			yz_s2 <= bsp_pkg::qmul(y_s1, z_s1);
			s_s2 <= x_s1 + y_s1 + z_s1;
			a_s2 <= y_s1 - x_s1;
			b_s2 <= z_s1 - y_s1;
			c_s2 <= x_s1 - z_s1;
			px_s3 <= 2 * x2_s2 - y2_s2 - z2_s2 + 2 * bsp_pkg::qmul(yz_s2, y2_s2 - z2_s2)
				+ bsp_pkg::qmul(zx_s2, x2_s2 - z2_s2) + bsp_pkg::qmul(xy_s2, y2_s2 - x2_s2);
			py_s3 <= y2_s2 - z2_s2 + bsp_pkg::qmul(zx_s2, z2_s2 - x2_s2)
				+ bsp_pkg::qmul(xy_s2, y2_s2 - x2_s2);
			ss_s3 <= bsp_pkg::qmul(s_s2, s_s2);
			ab_s3 <= bsp_pkg::qmul(a_s2, b_s2);
			s_s3 <= s_s2;
			c_s3 <= c_s2;
			px_s4 <= px_s3 >>> 1;
			py_s4 <= bsp_pkg::qmul(34'(bsp_pkg::SQRT3_HALF_Q), py_s3);
			s3_s4 <= bsp_pkg::qmul(ss_s3, s_s3);
			p_s4 <= bsp_pkg::qmul(ab_s3, c_s3);
			s_s4 <= s_s3;
			px_s5 <= px_s4;
			py_s5 <= py_s4;
			pz_s5 <= bsp_pkg::qmul(s_s4, s3_s4 + 4 * p_s4);
			px_s6 <= px_s5;
			py_s6 <= py_s5;
			pz_s6 <= 34'(bsp_pkg::rsh(64'(zprod), 16));
		end
	end

	function automatic logic signed [bsp_pkg::OUT_W-1:0] to_out(input w_t v);
		logic signed [63:0] t;
		begin
			t = 64'(v);
			if (FRAC_BITS >= bsp_pkg::IQ) t = t <<< (FRAC_BITS - bsp_pkg::IQ);
			else t = bsp_pkg::rsh(t, bsp_pkg::IQ - FRAC_BITS);
			if (t > 64'sd524287) t = 64'sd524287;
			if (t < -64'sd524288) t = -64'sd524288;
			to_out = t[bsp_pkg::OUT_W-1:0];
		end
	endfunction

	always_comb begin
		res.x_coord = to_out(px_s6);
		res.y_coord = to_out(py_s6);
		res.z_coord = to_out(pz_s6);
	end
endmodule

FILE: rtl/boy_surface_point_eval.sv
// Boy's surface point evaluator.
// in_*: request of (u_angle, v_angle), turn fractions, valid/ready.
// out_*: request of (x_coord, y_coord, z_coord), signed, FRAC_BITS
//   fraction bits, saturated to 20 bits, valid/ready.
// cfg_*: write of z_scale (unsigned Q0.16), reset 0.125.
// Stages: 12 sine, then 6 poly, from accept to out_valid.
// Throughput: one point per cycle when not stalled; pipeline advances as one unit.
// Stall: when out_valid is high and out_ready low, all stages hold
//   and in_ready drops; nothing is lost or repeated.
// Reset: valid bits clear, z_scale returns to 8192.
// cfg_ready is always high; write only when the pipe is empty.
module boy_surface_point_eval #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bsp_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output bsp_pkg::out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bsp_pkg::CFG_W-1:0] cfg_data
);
	localparam int LAT = 18;
	logic [LAT-1:0] vld_q;
	logic [bsp_pkg::CFG_W-1:0] z_scale_q;
	logic en;
	logic signed [31:0] su, cu, sv, cv;

	// whole pipe moves unless the head is stuck
	assign en = !(vld_q[LAT-1] && !out_ready);
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			z_scale_q <= bsp_pkg::Z_SCALE_RESET;
		end else begin
			if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
			if (cfg_valid) z_scale_q <= cfg_data;
		end
	end

	bsp_sin u_su (.clk, .en, .ang(in_data.u_angle), .res(su));
	bsp_sin u_cu (.clk, .en, .ang(in_data.u_angle + 16'd16384), .res(cu));
	bsp_sin u_sv (.clk, .en, .ang(in_data.v_angle), .res(sv));
	bsp_sin u_cv (.clk, .en, .ang(in_data.v_angle + 16'd16384), .res(cv));

	bsp_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
		.clk, .en, .su, .cu, .sv, .cv, .z_scale(z_scale_q), .res(out_data)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !(out_valid && !out_ready))
		else $error("in_ready wrong");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted request lost");
endmodule

FILE: sim/tb_top.sv
`default_nettype none

// Boy's surface point evaluator bench.
// A directed stimulus table goes first, then random angle pairs. Everything
// is scored against a behavioral Q28 model of the surface math kept in here.
// The z scale register is reprogrammed between phases, only while the pipe
// is drained. Sender bursts and receiver stalls change from phase to phase.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 16;
	localparam int IDLE_LIMIT = 4000;   // cycles with no handshake at all
	localparam int PIPE_DEPTH = 18;     // accept to out_valid
	localparam longint ONE_Q = 64'sd1 <<< 28;
	localparam longint HALF_PI = 64'sd421657428;
	localparam longint SQRT3_HALF = 64'sd232471924;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	bsp_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	bsp_pkg::out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [bsp_pkg::CFG_W-1:0] cfg_data;

	boy_surface_point_eval #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// bench-side copy of the scale register
	logic [15:0] zscale_model;
	bsp_pkg::out_t pending_points[$];
	int errors;
	int points_in;
	int points_out;
	int scale_writes;
	int idle_cycles;

	// sender / receiver behavior knobs, set per phase
	bit sender_gaps;
	int burst_left;
	int stall_mode;   // 0 always ready, 1 random stalls, 2 periodic stalls
	int stall_pct;
	int cyc;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------- model of the surface math (Q28) ----------------

	// rounded half-up product of two Q28 values
	function automatic longint q28_mul(input longint a, input longint b);
		longint p;
		p = a * b + (64'sd1 <<< 27);
		return p >>> 28;
	endfunction

	// sine over a quarter turn, phase t in [0, 16384]
	function automatic longint quarter_sine(input int unsigned t);
		longint x;
		longint x2;
		longint r;
		x = longint'((longint'(t) * HALF_PI + 8192) >> 14);
		x2 = q28_mul(x, x);
		r = ONE_Q - x2 / 110;
		r = ONE_Q - q28_mul(x2, r) / 72;
		r = ONE_Q - q28_mul(x2, r) / 42;
		r = ONE_Q - q28_mul(x2, r) / 20;
		r = ONE_Q - q28_mul(x2, r) / 6;
		r = q28_mul(x, r);
		if (r > ONE_Q)
			r = ONE_Q;
		return r;
	endfunction

	// sine of an angle given as a fraction of a full turn
	function automatic longint turn_sine(input logic [15:0] a);
		longint s;
		if (a[14])
			s = quarter_sine(16384 - int'(a[13:0]));
		else
			s = quarter_sine(int'(a[13:0]));
		return a[15] ? -s : s;
	endfunction

	// Q28 to output format: rounded shift, then clamp to 20 bits
	function automatic logic signed [19:0] q28_to_coord(input longint v);
		longint r;
		r = (v + (64'sd1 <<< (28 - FRAC_BITS - 1))) >>> (28 - FRAC_BITS);
		if (r > 524287)
			r = 524287;
		if (r < -524288)
			r = -524288;
		return r[19:0];
	endfunction

	function automatic bsp_pkg::out_t boy_point(input bsp_pkg::in_t p,
			input logic [15:0] zs);
		longint su, cu, sv, cv;
		longint xs, ys, zz, xx, yy, zq, xy, zx, yz;
		longint px, py, s, s3, w, pz;
		bsp_pkg::out_t o;
		su = turn_sine(p.u_angle);
		cu = turn_sine(p.u_angle + 16'd16384);
		sv = turn_sine(p.v_angle);
		cv = turn_sine(p.v_angle + 16'd16384);
		// point on the unit sphere
		xs = q28_mul(cu, sv);
		ys = q28_mul(su, sv);
		zz = cv;
		xx = q28_mul(xs, xs);
		yy = q28_mul(ys, ys);
		zq = q28_mul(zz, zz);
		xy = q28_mul(xs, ys);
		zx = q28_mul(zz, xs);
		yz = q28_mul(ys, zz);
		px = 2 * xx - yy - zq + 2 * q28_mul(yz, yy - zq)
			+ q28_mul(zx, xx - zq) + q28_mul(xy, yy - xx);
		px = px >>> 1;   // floor halving
		py = yy - zq + q28_mul(zx, zq - xx) + q28_mul(xy, yy - xx);
		py = q28_mul(SQRT3_HALF, py);
		s = xs + ys + zz;
		s3 = q28_mul(q28_mul(s, s), s);
		w = s3 + 4 * q28_mul(q28_mul(ys - xs, zz - ys), xs - zz);
		pz = q28_mul(s, w);
		pz = (pz * longint'(zs) + 32768) >>> 16;
		o.x_coord = q28_to_coord(px);
		o.y_coord = q28_to_coord(py);
		o.z_coord = q28_to_coord(pz);
		return o;
	endfunction

	// ---------------- handshake monitor and scoreboard ----------------

	always @(posedge clk or negedge arst_n) begin
		bsp_pkg::out_t want;
		bit moved;
		if (!arst_n) begin
			zscale_model <= bsp_pkg::Z_SCALE_RESET;
		end else begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				zscale_model <= cfg_data;
				scale_writes++;
				moved = 1'b1;
			end
			if (in_valid && in_ready) begin
				pending_points.push_back(boy_point(in_data, zscale_model));
				points_in++;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				points_out++;
				if (pending_points.size() == 0) begin
					$error("unexpected result x=%0d y=%0d z=%0d",
						out_data.x_coord, out_data.y_coord, out_data.z_coord);
					errors++;
				end else begin
					want = pending_points.pop_front();
					if (out_data.x_coord !== want.x_coord) begin
						$error("x_coord expected %0d got %0d",
							want.x_coord, out_data.x_coord);
						errors++;
					end
					if (out_data.y_coord !== want.y_coord) begin
						$error("y_coord expected %0d got %0d",
							want.y_coord, out_data.y_coord);
						errors++;
					end
					if (out_data.z_coord !== want.z_coord) begin
						$error("z_coord expected %0d got %0d",
							want.z_coord, out_data.z_coord);
						errors++;
					end
				end
			end
			// watchdog: counts cycles with no handshake anywhere
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// receiver back-pressure; periodic mode holds ready low on a repeating pattern
	always @(posedge clk) begin
		cyc++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 99) >= stall_pct);
			default: out_ready <= ((cyc % 7) >= 3);
		endcase
	end

	// ---------------- stimulus ----------------

	// one request; valid stays up across a burst, drops for the gaps
	task automatic send_point(input bsp_pkg::in_t p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (sender_gaps) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		in_data <= p;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!(in_valid && in_ready))
			@(posedge clk);
	endtask

	// drop valid and wait for the pipe to drain before touching the register
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_scale(input logic [15:0] val);
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready))
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// angle picker: half the time near a quadrant boundary, where the
	// sine folding and clamp live
	function automatic logic [15:0] pick_angle();
		logic [15:0] a;
		if ($urandom_range(0, 1)) begin
			a = 16'($urandom_range(0, 65535));
		end else begin
			a = {2'($urandom_range(0, 3)), 14'd0};
			a = a + 16'($urandom_range(0, 6)) - 16'd3;
		end
		return a;
	endfunction

	task automatic random_phase(input int count);
		bsp_pkg::in_t p;
		for (int i = 0; i < count; i++) begin
			p.u_angle = pick_angle();
			p.v_angle = pick_angle();
			send_point(p);
		end
	endtask

	// directed rows: axis angles, turn extremes, quadrant edges, all-ones
	localparam int DIR_ROWS = 20;
	logic [15:0] dir_rows[DIR_ROWS][2] = '{
		'{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF}, '{16'h0000, 16'hFFFF},
		'{16'hFFFF, 16'h0000}, '{16'h4000, 16'h4000}, '{16'h8000, 16'h8000},
		'{16'hC000, 16'hC000}, '{16'h3FFF, 16'h4001}, '{16'h7FFF, 16'h8001},
		'{16'hBFFF, 16'hC001}, '{16'h0001, 16'h3FFF}, '{16'h5555, 16'hAAAA},
		'{16'hAAAA, 16'h5555}, '{16'h2000, 16'h2000}, '{16'h6000, 16'hE000},
		'{16'h1C72, 16'h1555}, '{16'hE38E, 16'h6AAB}, '{16'h0000, 16'h4000},
		'{16'h4000, 16'h0000}, '{16'h8000, 16'h4000}
	};

	logic [15:0] scale_steps[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd8192};

	initial begin
		bsp_pkg::in_t p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		points_in = 0;
		points_out = 0;
		scale_writes = 0;
		idle_cycles = 0;
		cyc = 0;
		burst_left = 0;
		sender_gaps = 1'b0;
		stall_mode = 0;
		stall_pct = 30;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset scale, no back-pressure
		foreach (dir_rows[i]) begin
			p.u_angle = dir_rows[i][0];
			p.v_angle = dir_rows[i][1];
			send_point(p);
		end
		drain_pipe();
		// same table at the largest scale, where z saturates most readily
		write_scale(16'hFFFF);
		foreach (dir_rows[i]) begin
			p.u_angle = dir_rows[i][0];
			p.v_angle = dir_rows[i][1];
			send_point(p);
		end
		drain_pipe();

		// random phases: one at the largest scale, then one per scale step,
		// then a random scale; flow control varies per phase
		sender_gaps = 1'b1;
		stall_mode = 1;
		random_phase(260);
		for (int ph = 0; ph < 5; ph++) begin
			drain_pipe();
			write_scale(ph < 4 ? scale_steps[ph] : 16'($urandom_range(0, 65535)));
			sender_gaps = (ph % 2) == 0;
			stall_mode = (ph + 2) % 3;
			stall_pct = $urandom_range(10, 70);
			random_phase(260);
		end
		drain_pipe();

		$display("%0d points sent, %0d checked, %0d scale writes (0, 1, 0.125, max,",
			points_in, points_out, scale_writes);
		$display("random) under bursty input and random/periodic output stalls");
		if (errors == 0 && pending_points.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_points.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
